@@ rtl/percentile_beat_detector_led_fade_macros.svh @@
// Assertion macros shared by the beat detector RTL files.
`ifndef PERCENTILE_BEAT_DETECTOR_LED_FADE_MACROS_SVH
`define PERCENTILE_BEAT_DETECTOR_LED_FADE_MACROS_SVH
`ifndef SYNTHESIS
`define PBD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PBD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define PBD_ASSERT(lbl, prop, msg)
`define PBD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ rtl/pbd_pkg.sv @@
// Package with the shared types, constants and fade tables of the beat detector.
`timescale 1ns / 1ps
package pbd_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int THR_W      = 14;
	localparam int GAP_W      = 16;
	localparam int LEVEL_W    = 5;
	localparam int DUTY_W     = 8;
	localparam int HOLD_W     = 5;
	localparam int TIME_W     = 32;
	localparam int FADE_STEPS = 27;

	localparam logic [THR_W-1:0]   THR_RESET   = 14'd15;
	localparam logic [GAP_W-1:0]   GAP_RESET   = 16'd100;
	localparam logic [LEVEL_W-1:0] START_RESET = 5'd27;

	localparam logic [DUTY_W-1:0] INSTANT_HI_DUTY = 8'd190;
	localparam logic [DUTY_W-1:0] INSTANT_LO_DUTY = 8'd3;
	localparam logic [HOLD_W-1:0] INSTANT_HOLD    = 5'd16;

	localparam logic [DUTY_W-1:0] FADE_DUTY [0:FADE_STEPS] = '{
		8'd0,   8'd3,   8'd7,   8'd14,  8'd22,  8'd29,  8'd37,
		8'd44,  8'd52,  8'd59,  8'd67,  8'd74,  8'd81,  8'd89,
		8'd96,  8'd104, 8'd111, 8'd119, 8'd126, 8'd134, 8'd141,
		8'd149, 8'd156, 8'd163, 8'd171, 8'd178, 8'd186, 8'd190
	};

	localparam logic [HOLD_W-1:0] FADE_HOLD [0:FADE_STEPS] = '{
		5'd0, 5'd1, 5'd3, 5'd3, 5'd3, 5'd3, 5'd3,
		5'd3, 5'd3, 5'd5, 5'd5, 5'd5, 5'd5, 5'd6,
		5'd5, 5'd5, 5'd4, 5'd3, 5'd2, 5'd3, 5'd3,
		5'd3, 5'd3, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2
	};

	typedef enum logic [1:0] {
		CFG_SILENCE_THR = 2'd0,
		CFG_BEAT_GAP    = 2'd1,
		CFG_INSTANT     = 2'd2,
		CFG_START_LEVEL = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic beat_go;
		logic fade_go;
	} fade_ctl_t;

	typedef struct packed {
		logic              has;
		logic [DUTY_W-1:0] duty;
		logic [HOLD_W-1:0] hold;
	} fade_entry_t;

	function automatic fade_entry_t fade_lookup(logic [LEVEL_W-1:0] level, logic instant);
		fade_entry_t ent;
		ent = '0;
		if (instant) begin
			if (level == LEVEL_W'(2)) begin
				ent.has  = 1'b1;
				ent.duty = INSTANT_HI_DUTY;
				ent.hold = INSTANT_HOLD;
			end else if (level == LEVEL_W'(1)) begin
				ent.has  = 1'b1;
				ent.duty = INSTANT_LO_DUTY;
				ent.hold = INSTANT_HOLD;
			end
		end else if (level <= LEVEL_W'(FADE_STEPS)) begin
			ent.has  = 1'b1;
			ent.duty = FADE_DUTY[level];
			ent.hold = FADE_HOLD[level];
		end
		return ent;
	endfunction

endpackage

@@ rtl/percentile_beat_detector_led_fade.sv @@
// Top level of the percentile beat detector with LED fade output.
//
// The input channel takes one microphone sample and the millisecond time per
// transaction, accepted when in_valid is high and in_stall is low. The block
// holds in_stall high from that edge until the result is loaded into the
// output register, so it works on one transaction at a time.
// Each item visits every ring entry as a candidate and scans the whole ring
// with one shared pair of comparators through the single read port of the
// ring. A new transaction is accepted no earlier than the cycle after the
// result is loaded into the output register.
// The result sits in an output register; if out_stall holds it, the next
// result waits in the final state until that register is taken.
// Configuration writes use cfg_valid and cfg_ready and are always accepted;
// the user must make them only while the block is idle; nothing enforces it.
// Reset empties the ring (unwritten entries read as zeros) and sets the
// deadlines, fade level and registers to defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`include "percentile_beat_detector_led_fade_macros.svh"
module percentile_beat_detector_led_fade import pbd_pkg::*; #(
	parameter int RING_DEPTH  = 64,
	parameter int SAMPLE_BITS = 14
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [SAMPLE_BITS-1:0] mic_sample,
	input  logic [TIME_W-1:0]      now_ms,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   beat,
	output logic                   led_write,
	output logic [DUTY_W-1:0]      led_duty,
	output logic [LEVEL_W-1:0]     fade_level_now,
	output logic [SAMPLE_BITS-1:0] ring_min,
	output logic [SAMPLE_BITS-1:0] low_pct,
	output logic [SAMPLE_BITS-1:0] median_value,
	output logic [SAMPLE_BITS-1:0] high_pct,
	output logic [SAMPLE_BITS-1:0] ring_max,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  cfg_reg_t               cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int SW = SAMPLE_BITS;

	typedef enum logic [2:0] {
		T_IDLE,
		T_RANK,
		T_BEAT,
		T_FADE,
		T_OUT
	} top_state_t;

	top_state_t         state_q;
	logic [SW-1:0]      sample_q;
	logic [TIME_W-1:0]  now_q;
	logic               phase_q;
	logic [THR_W-1:0]   thr_q;
	logic [GAP_W-1:0]   gap_q;
	logic               instant_q;
	logic [LEVEL_W-1:0] start_lvl_q;

	logic               out_valid_q;
	logic               beat_q;
	logic               led_write_q;
	logic [DUTY_W-1:0]  led_duty_q;
	logic [LEVEL_W-1:0] level_out_q;
	logic [SW-1:0]      min_q, lo_q, mid_q, hi_q, max_q;

	logic               in_acc;
	logic               rank_done;
	logic [AW-1:0]      rd_addr;
	logic [SW-1:0]      rd_data;
	logic               ring_wr;
	logic               out_load;
	fade_ctl_t          fade_ctl;
	logic [SW-1:0]      rk_min, rk_lo, rk_mid, rk_hi, rk_max;
	logic               fd_beat, fd_wr;
	logic [DUTY_W-1:0]  fd_duty;
	logic [LEVEL_W-1:0] fd_level;

	assign in_stall         = (state_q != T_IDLE);
	assign in_acc           = in_valid && !in_stall;
	assign cfg_ready        = 1'b1;
	assign ring_wr          = (state_q == T_FADE) && !phase_q;
	assign fade_ctl.beat_go = (state_q == T_BEAT);
	assign fade_ctl.fade_go = (state_q == T_FADE);
	assign out_load         = (state_q == T_OUT) && (!out_valid_q || !out_stall);

	pbd_ring #(
		.N  (RING_DEPTH),
		.SW (SW)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (ring_wr),
		.wr_data (sample_q)
	);

	pbd_rank #(
		.N  (RING_DEPTH),
		.SW (SW)
	) u_rank (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (in_acc),
		.done         (rank_done),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.ring_min     (rk_min),
		.low_pct      (rk_lo),
		.median_value (rk_mid),
		.high_pct     (rk_hi),
		.ring_max     (rk_max)
	);

	pbd_fade #(
		.SW (SW)
	) u_fade (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (fade_ctl),
		.sample            (sample_q),
		.now               (now_q),
		.lo                (rk_lo),
		.hi                (rk_hi),
		.silence_threshold (thr_q),
		.min_beat_gap_ms   (gap_q),
		.instant_mode      (instant_q),
		.fade_start_level  (start_lvl_q),
		.beat              (fd_beat),
		.led_write         (fd_wr),
		.led_duty          (fd_duty),
		.fade_level_now    (fd_level)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= mic_sample;
			now_q    <= now_ms;
		end
		if (out_load) begin
			beat_q      <= fd_beat;
			led_write_q <= fd_wr;
			led_duty_q  <= fd_duty;
			level_out_q <= fd_level;
			min_q       <= rk_min;
			lo_q        <= rk_lo;
			mid_q       <= rk_mid;
			hi_q        <= rk_hi;
			max_q       <= rk_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
			thr_q       <= THR_RESET;
			gap_q       <= GAP_RESET;
			instant_q   <= 1'b0;
			start_lvl_q <= START_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_SILENCE_THR: thr_q       <= cfg_data[THR_W-1:0];
					CFG_BEAT_GAP:    gap_q       <= cfg_data[GAP_W-1:0];
					CFG_INSTANT:     instant_q   <= cfg_data[0];
					CFG_START_LEVEL: start_lvl_q <= cfg_data[LEVEL_W-1:0];
				endcase
			end
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (in_acc) begin
						state_q <= T_RANK;
					end
				end
				T_RANK: begin
					if (rank_done) begin
						state_q <= T_BEAT;
					end
				end
				T_BEAT: state_q <= T_FADE;
				T_FADE: begin
					phase_q <= ~phase_q;
					state_q <= T_OUT;
				end
				T_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign beat           = beat_q;
	assign led_write      = led_write_q;
	assign led_duty       = led_duty_q;
	assign fade_level_now = level_out_q;
	assign ring_min       = min_q;
	assign low_pct        = lo_q;
	assign median_value   = mid_q;
	assign high_pct       = hi_q;
	assign ring_max       = max_q;

	`PBD_ASSERT(a_done_in_rank, !rank_done || state_q == T_RANK, "Rank done outside rank phase.")
	`PBD_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall, "Block not busy after a transaction.")
	`PBD_ASSERT_NEXT(a_phase_toggles, state_q == T_FADE, phase_q != $past(phase_q), "Phase stuck.")

endmodule

@@ rtl/pbd_ring.sv @@
// Sample ring memory with its write pointer and fill tracking.
`timescale 1ns / 1ps
module pbd_ring import pbd_pkg::*; #(
	parameter int N  = 64,
	parameter int SW = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [$clog2(N)-1:0] rd_addr,
	output logic [SW-1:0]        rd_data,
	input  logic                 wr_en,
	input  logic [SW-1:0]        wr_data
);

	localparam int AW = $clog2(N);

	logic [SW-1:0] mem [0:N-1];
	logic [SW-1:0] rd_q;
	logic          vld_q;
	logic [AW-1:0] wpos_q;
	logic          full_q;
	logic [AW-1:0] wpos_nxt;

	assign wpos_nxt = (wpos_q == AW'(N - 1)) ? '0 : wpos_q + AW'(1);
	assign rd_data  = vld_q ? rd_q : '0;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wpos_nxt] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			full_q <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			vld_q <= full_q || ((rd_addr != '0) && (rd_addr <= wpos_q));
			if (wr_en) begin
				wpos_q <= wpos_nxt;
				if (wpos_nxt == '0) begin
					full_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/pbd_rank.sv @@
// Rank selector that counts smaller and not-larger samples for each ring entry.
`timescale 1ns / 1ps
`include "percentile_beat_detector_led_fade_macros.svh"
module pbd_rank import pbd_pkg::*; #(
	parameter int N  = 64,
	parameter int SW = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 done,
	output logic [$clog2(N)-1:0] rd_addr,
	input  logic [SW-1:0]        rd_data,
	output logic [SW-1:0]        ring_min,
	output logic [SW-1:0]        low_pct,
	output logic [SW-1:0]        median_value,
	output logic [SW-1:0]        high_pct,
	output logic [SW-1:0]        ring_max
);

	localparam int AW    = $clog2(N);
	localparam int CW    = $clog2(N + 1);
	localparam int R_LO  = N / 20;
	localparam int R_MID = N / 2;
	localparam int R_HI  = N - N / 20;
	localparam int R_MX  = N - 1;

	typedef enum logic [2:0] {
		R_IDLE,
		R_CAND,
		R_LOAD,
		R_SCAN,
		R_DRAIN,
		R_CHECK
	} rank_state_t;

	rank_state_t   state_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [SW-1:0] cand_q;
	logic [CW-1:0] less_q;
	logic [CW-1:0] leq_q;
	logic          done_q;
	logic [SW-1:0] min_q, lo_q, mid_q, hi_q, max_q;
	logic          is_lt;
	logic          is_le;

	assign is_lt = rd_data < cand_q;
	assign is_le = rd_data <= cand_q;

	always_comb begin
		unique case (state_q)
			R_CAND:  rd_addr = i_q;
			R_LOAD:  rd_addr = j_q;
			R_SCAN:  rd_addr = j_q;
			default: rd_addr = i_q;
		endcase
	end

	assign done         = done_q;
	assign ring_min     = min_q;
	assign low_pct      = lo_q;
	assign median_value = mid_q;
	assign high_pct     = hi_q;
	assign ring_max     = max_q;

	always_ff @(posedge clk) begin
		if (state_q == R_LOAD) begin
			cand_q <= rd_data;
		end
		if (state_q == R_CHECK) begin
			if ((less_q == '0) && (leq_q != '0)) begin
				min_q <= cand_q;
			end
			if ((less_q <= CW'(R_LO)) && (CW'(R_LO) < leq_q)) begin
				lo_q <= cand_q;
			end
			if ((less_q <= CW'(R_MID)) && (CW'(R_MID) < leq_q)) begin
				mid_q <= cand_q;
			end
			if ((less_q <= CW'(R_HI)) && (CW'(R_HI) < leq_q)) begin
				hi_q <= cand_q;
			end
			if ((less_q <= CW'(R_MX)) && (CW'(R_MX) < leq_q)) begin
				max_q <= cand_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			less_q  <= '0;
			leq_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				R_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						i_q     <= '0;
						state_q <= R_CAND;
					end
				end
				R_CAND: begin
					j_q     <= '0;
					state_q <= R_LOAD;
				end
				R_LOAD: begin
					less_q  <= '0;
					leq_q   <= '0;
					j_q     <= j_q + AW'(1);
					state_q <= R_SCAN;
				end
				R_SCAN: begin
					less_q <= less_q + CW'(is_lt);
					leq_q  <= leq_q + CW'(is_le);
					if (j_q == AW'(N - 1)) begin
						state_q <= R_DRAIN;
					end else begin
						j_q <= j_q + AW'(1);
					end
				end
				R_DRAIN: begin
					less_q  <= less_q + CW'(is_lt);
					leq_q   <= leq_q + CW'(is_le);
					state_q <= R_CHECK;
				end
				R_CHECK: begin
					if (i_q == AW'(N - 1)) begin
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end else begin
						i_q     <= i_q + AW'(1);
						state_q <= R_CAND;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	`PBD_ASSERT(a_leq_ge_less, leq_q >= less_q, "Rank counts out of order.")
	`PBD_ASSERT_NEXT(a_done_pulse, done_q, !done_q && state_q == R_IDLE, "Done is not a single pulse.")
	`PBD_ASSERT_NEXT(a_check_after_drain, state_q == R_DRAIN, state_q == R_CHECK, "Drain did not lead to check.")

endmodule

@@ rtl/pbd_fade.sv @@
// Beat decision, refractory timing and LED fade sequencing.
`timescale 1ns / 1ps
module pbd_fade import pbd_pkg::*; #(
	parameter int SW = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fade_ctl_t          ctl,
	input  logic [SW-1:0]      sample,
	input  logic [TIME_W-1:0]  now,
	input  logic [SW-1:0]      lo,
	input  logic [SW-1:0]      hi,
	input  logic [THR_W-1:0]   silence_threshold,
	input  logic [GAP_W-1:0]   min_beat_gap_ms,
	input  logic               instant_mode,
	input  logic [LEVEL_W-1:0] fade_start_level,
	output logic               beat,
	output logic               led_write,
	output logic [DUTY_W-1:0]  led_duty,
	output logic [LEVEL_W-1:0] fade_level_now
);

	logic [LEVEL_W-1:0] level_q;
	logic [TIME_W-1:0]  beat_dl_q;
	logic [TIME_W-1:0]  blink_dl_q;
	logic               beat_q;
	logic               wr_q;
	logic [DUTY_W-1:0]  duty_q;
	logic [SW-1:0]      spread;
	logic               hit;
	fade_entry_t        ent;

	assign spread = hi - lo;
	assign hit    = ((sample > hi) || (sample < lo)) &&
			(TIME_W'(spread) > TIME_W'(silence_threshold)) && (now > beat_dl_q);
	assign ent    = fade_lookup(level_q, instant_mode);

	assign beat           = beat_q;
	assign led_write      = wr_q;
	assign led_duty       = duty_q;
	assign fade_level_now = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= '0;
			beat_dl_q  <= '0;
			blink_dl_q <= '0;
			beat_q     <= 1'b0;
			wr_q       <= 1'b0;
			duty_q     <= '0;
		end else begin
			if (ctl.beat_go) begin
				beat_q <= hit;
				wr_q   <= 1'b0;
				duty_q <= '0;
				if (hit) begin
					level_q   <= fade_start_level;
					beat_dl_q <= now + TIME_W'(min_beat_gap_ms);
				end
			end
			if (ctl.fade_go) begin
				if ((level_q != '0) && (now >= blink_dl_q)) begin
					if (ent.has) begin
						wr_q       <= 1'b1;
						duty_q     <= ent.duty;
						blink_dl_q <= now + TIME_W'(ent.hold);
					end
					level_q <= level_q - LEVEL_W'(1);
				end
			end
		end
	end

endmodule
